// ----- src/ntc_pkg.sv -----
// Package: type codes, field widths and helper functions for the numeric type converter.
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CodeW = 4;

  localparam logic [CodeW-1:0] TYPE_U8  = 4'd0;
  localparam logic [CodeW-1:0] TYPE_U16 = 4'd1;
  localparam logic [CodeW-1:0] TYPE_U32 = 4'd2;
  localparam logic [CodeW-1:0] TYPE_U64 = 4'd3;
  localparam logic [CodeW-1:0] TYPE_I8  = 4'd4;
  localparam logic [CodeW-1:0] TYPE_I16 = 4'd5;
  localparam logic [CodeW-1:0] TYPE_I32 = 4'd6;
  localparam logic [CodeW-1:0] TYPE_I64 = 4'd7;
  localparam logic [CodeW-1:0] TYPE_F32 = 4'd8;
  localparam logic [CodeW-1:0] TYPE_F64 = 4'd9;

  // Leading zero count of a 64-bit word; 64 when the word is zero.
  function automatic logic [6:0] lzc64(input logic [WordW-1:0] x);
    logic [6:0] n;
    logic       found;
    n     = 7'd64;
    found = 1'b0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!found && x[i]) begin
        n     = 7'(WordW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Mask of the low 8 << (code & 3) bits.
  function automatic logic [WordW-1:0] width_mask(input logic [CodeW-1:0] code);
    logic [WordW-1:0] m;
    case (code[1:0])
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- src/ntc_in_if.sv -----
// Interface: input channel carrying the raw word and the two type codes.
`timescale 1ns / 1ps

interface ntc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_value;
  logic [3:0]  source_type;
  logic [3:0]  target_type;

  modport source (output valid, output raw_value, output source_type, output target_type,
                  input ready);
  modport sink (input valid, input raw_value, input source_type, input target_type,
                output ready);
endinterface

// ----- src/ntc_out_if.sv -----
// Interface: output channel carrying the converted word and its flags.
`timescale 1ns / 1ps

interface ntc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] converted_bits;
  logic        range_clipped;
  logic        type_error;

  modport source (output valid, output converted_bits, output range_clipped,
                  output type_error, input ready);
  modport sink (input valid, input converted_bits, input range_clipped,
                input type_error, output ready);
endinterface

// ----- src/numeric_type_converter_unit.sv -----
// Top level: integer and IEEE 754 float conversion, one per cycle without stalls.
`timescale 1ns / 1ps

// Channel   Dir  Payload
// in_ch     in   raw_value[63:0], source_type[3:0], target_type[3:0]
// out_ch    out  converted_bits[63:0], range_clipped, type_error
//
// Two register stages: an input register and a result register, with the
// whole conversion as combinational logic between them. An accepted input
// passes the input register and then the result register; one transaction
// per cycle is sustained while out_ch does not stall. Stalls on out_ch
// propagate back through ready; a stage advances whenever it is empty or
// the stage after it advances. rst (synchronous) empties both stages.
module numeric_type_converter_unit (
  input  logic      clk,
  input  logic      rst,
  ntc_in_if.sink    in_ch,
  ntc_out_if.source out_ch
);
  import ntc_pkg::*;

  // Input register stage.
  logic             s1_valid;
  logic [WordW-1:0] s1_raw;
  logic [CodeW-1:0] s1_st;
  logic [CodeW-1:0] s1_dt;

  // Result register stage.
  logic             out_valid;
  logic [WordW-1:0] out_bits;
  logic             out_clip;
  logic             out_err;

  logic adv_out;
  logic adv_in;

  assign adv_out     = !out_valid || out_ch.ready;
  assign adv_in      = !s1_valid || adv_out;
  assign in_ch.ready = adv_in;

  // Conversion results.
  logic [WordW-1:0] res;
  logic             clip;
  logic             err;

  // Integer source path.
  logic [WordW-1:0] pat;
  logic [WordW-1:0] smask;
  logic             neg;
  logic [WordW-1:0] imag;
  logic [6:0]       ilz;
  logic [WordW-1:0] inorm;
  logic             ig32;
  logic             ig64;
  logic [30:0]      ival32;
  logic [62:0]      ival64;

  // Float source decode.
  logic             fs;
  logic             finf;
  logic             fnan;
  logic             fzero_exp;
  logic [51:0]      ffrac;
  logic signed [12:0] fexp;
  logic [WordW-1:0] falign;

  // Float to float.
  logic [6:0]       slz;
  logic [WordW-1:0] snorm;
  logic [10:0]      sbias64;
  logic [52:0]      dm;
  logic [116:0]     dshift;
  logic [5:0]       damt;
  logic             drnd;
  logic [30:0]      dval;

  // Float to integer.
  logic             huge;
  logic [WordW-1:0] fmag;
  logic [WordW-1:0] umax;
  logic [WordW-1:0] smax;
  logic [5:0]       famt;

  always_comb begin
    res  = '0;
    clip = 1'b0;
    err  = 1'b0;

    // Sign-extend signed integer sources; unsigned sources take the whole word.
    smask = width_mask(s1_st);
    pat   = s1_raw;
    if (s1_st[2] && !s1_st[3]) begin
      pat = s1_raw & smask;
      if (((s1_raw & ~(smask >> 1)) & smask) != '0) begin
        pat = pat | ~smask;
      end
    end
    neg  = s1_st[2] && !s1_st[3] && pat[WordW-1];
    imag = neg ? (WordW'(0) - pat) : pat;
    ilz  = lzc64(imag);
    inorm = imag << ilz[5:0];
    // Round to nearest even on the normalized magnitude.
    ig32 = inorm[39] && ((|inorm[38:0]) || inorm[40]);
    ig64 = inorm[10] && ((|inorm[9:0]) || inorm[11]);
    ival32 = {8'(8'd190 - 8'(ilz)), inorm[62:40]} + 31'(ig32);
    ival64 = {11'(11'd1086 - 11'(ilz)), inorm[62:11]} + 63'(ig64);

    // Decode the float source into sign, class, unbiased exponent, fraction.
    if (s1_st == TYPE_F32) begin
      fs        = s1_raw[31];
      ffrac     = {s1_raw[22:0], 29'b0};
      finf      = (s1_raw[30:23] == 8'hFF) && (s1_raw[22:0] == '0);
      fnan      = (s1_raw[30:23] == 8'hFF) && (s1_raw[22:0] != '0);
      fzero_exp = s1_raw[30:23] == 8'h00;
      fexp      = 13'(s1_raw[30:23]) - 13'sd127;
    end else begin
      fs        = s1_raw[63];
      ffrac     = s1_raw[51:0];
      finf      = (s1_raw[62:52] == 11'h7FF) && (s1_raw[51:0] == '0);
      fnan      = (s1_raw[62:52] == 11'h7FF) && (s1_raw[51:0] != '0);
      fzero_exp = s1_raw[62:52] == 11'h000;
      fexp      = 13'(s1_raw[62:52]) - 13'sd1023;
    end
    falign = {1'b1, ffrac, 11'b0};

    // Widen an f32 subnormal: normalize its fraction into an f64 normal.
    slz     = lzc64({41'b0, s1_raw[22:0]});
    snorm   = {41'b0, s1_raw[22:0]} << slz[5:0];
    sbias64 = 11'(11'd937 - 11'(slz));

    // Narrow f64 to f32.
    dm     = {1'b1, s1_raw[51:0]};
    damt   = 6'(-13'sd97 - fexp);
    dshift = {dm, 64'b0} >> damt;
    dval   = '0;
    if (fexp >= 13'sd128) begin
      dval = 31'h7F80_0000;
    end else if (fexp >= -13'sd126) begin
      drnd = dm[28] && ((|dm[27:0]) || dm[29]);
      dval = {8'(fexp + 13'sd127), dm[51:29]} + 31'(drnd);
    end else if (fexp >= -13'sd151) begin
      drnd = dshift[63] && ((|dshift[62:0]) || dshift[64]);
      dval = 31'(dshift[116:64]) + 31'(drnd);
    end
    drnd = 1'b0;

    // Float to integer: truncate toward zero, flag overflow.
    huge = finf || (!fzero_exp && fexp >= 13'sd64);
    famt = 6'(13'sd63 - fexp);
    fmag = '0;
    if (!fzero_exp && !finf && !fnan && fexp >= 13'sd0 && fexp < 13'sd64) begin
      fmag = falign >> famt;
    end
    umax = width_mask(s1_dt);
    smax = umax >> 1;

    if (s1_st > TYPE_F64 || s1_dt > TYPE_F64) begin
      err = 1'b1;
    end else if (s1_st == s1_dt) begin
      res = s1_raw;
    end else if (!s1_st[3]) begin
      if (!s1_dt[3]) begin
        res = pat & umax;
      end else if (s1_dt == TYPE_F32) begin
        res = (imag == '0) ? '0 : {32'b0, neg, ival32};
      end else begin
        res = (imag == '0) ? '0 : {neg, ival64};
      end
    end else if (s1_dt == TYPE_F64) begin
      // f32 source.
      if (finf) begin
        res = {fs, 11'h7FF, 52'b0};
      end else if (fnan) begin
        res = {fs, 11'h7FF, 1'b1, s1_raw[21:0], 29'b0};
      end else if (fzero_exp) begin
        res = (s1_raw[22:0] == '0) ? {fs, 63'b0} : {fs, sbias64, snorm[62:11]};
      end else begin
        res = {fs, 11'(fexp + 13'sd1023), s1_raw[22:0], 29'b0};
      end
    end else if (s1_dt == TYPE_F32) begin
      // f64 source.
      if (finf) begin
        res = {32'b0, fs, 31'h7F80_0000};
      end else if (fnan) begin
        res = {32'b0, fs, 9'h1FF, s1_raw[50:29]};
      end else if (fzero_exp) begin
        res = {32'b0, fs, 31'b0};
      end else begin
        res = {32'b0, fs, dval};
      end
    end else if (fnan) begin
      clip = 1'b1;
    end else if (!s1_dt[2]) begin
      if (fs) begin
        clip = huge || (fmag != '0);
      end else if (huge || fmag > umax) begin
        res  = umax;
        clip = 1'b1;
      end else begin
        res = fmag;
      end
    end else if (!fs) begin
      if (huge || fmag > smax) begin
        res  = smax;
        clip = 1'b1;
      end else begin
        res = fmag;
      end
    end else if (huge || fmag > smax + WordW'(1)) begin
      res  = (smax + WordW'(1)) & umax;
      clip = 1'b1;
    end else begin
      res = (WordW'(0) - fmag) & umax;
    end
  end

  // Advance the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_in) begin
      s1_valid <= in_ch.valid;
    end
    if (adv_in && in_ch.valid) begin
      s1_raw <= in_ch.raw_value;
      s1_st  <= in_ch.source_type;
      s1_dt  <= in_ch.target_type;
    end
  end

  // Advance the result stage; hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
    if (adv_out && s1_valid) begin
      out_bits <= res;
      out_clip <= clip;
      out_err  <= err;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.converted_bits = out_bits;
  assign out_ch.range_clipped  = out_clip;
  assign out_ch.type_error     = out_err;

endmodule

// ----- tb/sv/ntc_checker.sv -----
// Checker: watches both channels, predicts each conversion and compares results.
`timescale 1ns / 1ps

module ntc_checker (
  input  logic      clk,
  input  logic      rst,
  ntc_in_if.sink    in_mon,
  ntc_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending_count
);
  import ntc_pkg::*;

  typedef struct packed {
    logic [63:0] bits;
    logic        clipped;
    logic        bad_type;
  } conv_result_t;

  conv_result_t pending_results[$];

  function automatic int msb_index(input logic [63:0] x);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (x[i]) p = i;
    return p;
  endfunction

  // Round sign * m * 2^e into a binary float with mb significand bits.
  function automatic logic [63:0] round_pack(input logic s, input logic [63:0] m,
                                             input int e, input int mb, input int bias,
                                             input int emax, input int signpos);
    logic [63:0] sign_bit, fmask, q;
    int          qexp, shift, sh2, biased;
    logic        guard, sticky;
    sign_bit = s ? (64'd1 << signpos) : 64'd0;
    fmask    = (64'd1 << (mb - 1)) - 64'd1;
    qexp     = 1 - bias - (mb - 1);
    if (m == 64'd0) return sign_bit;
    shift = msb_index(m) - (mb - 1);
    sh2   = qexp - e;
    if (sh2 > shift) shift = sh2;
    if (shift <= 0) begin
      q = m << (-shift);
      guard = 1'b0;
      sticky = 1'b0;
    end else if (shift > 64) begin
      q = 64'd0;
      guard = 1'b0;
      sticky = 1'b1;
    end else if (shift == 64) begin
      q = 64'd0;
      guard = m[63];
      sticky = |m[62:0];
    end else begin
      q = m >> shift;
      guard = m[shift-1];
      sticky = (m & ((64'd1 << (shift - 1)) - 64'd1)) != 64'd0;
    end
    if (guard && (sticky || q[0])) q++;
    if ((q >> mb) != 64'd0) begin
      q = q >> 1;
      shift++;
    end
    if ((q >> (mb - 1)) != 64'd0) begin
      biased = e + shift + (mb - 1) + bias;
      if (biased >= emax) return sign_bit | (64'(emax) << (mb - 1));
      return sign_bit | (64'(biased) << (mb - 1)) | (q & fmask);
    end
    return sign_bit | q;
  endfunction

  function automatic conv_result_t convert(input logic [63:0] raw,
                                           input logic [3:0] st, input logic [3:0] dt);
    conv_result_t r;
    logic [63:0]  pat, mk, mag, frac, m, umax, smax;
    logic         neg, s, inf, nan, huge;
    int           w, e, ex;
    r = '0;
    if (st > TYPE_F64 || dt > TYPE_F64) begin
      r.bad_type = 1'b1;
      return r;
    end
    if (st == dt) begin
      r.bits = raw;
      return r;
    end
    if (st < TYPE_F32) begin
      pat = raw;
      if (st >= TYPE_I8) begin
        w   = 8 << st[1:0];
        mk  = width_mask(st);
        pat = raw & mk;
        if (w < 64 && pat[w-1]) pat = pat | ~mk;
      end
      if (dt < TYPE_F32) r.bits = pat & width_mask(dt);
      else begin
        neg = (st >= TYPE_I8) && pat[63];
        mag = neg ? -pat : pat;
        r.bits = (dt == TYPE_F32) ? round_pack(neg, mag, 0, 24, 127, 255, 31)
                                  : round_pack(neg, mag, 0, 53, 1023, 2047, 63);
      end
      return r;
    end
    inf = 1'b0;
    nan = 1'b0;
    if (st == TYPE_F32) begin
      ex   = raw[30:23];
      s    = raw[31];
      frac = {41'd0, raw[22:0]};
      if (ex == 255) begin
        inf = frac == 0;
        nan = !inf;
        m = 0;
        e = 0;
      end else if (ex == 0) begin
        m = frac;
        e = -149;
      end else begin
        m = frac | (64'd1 << 23);
        e = ex - 150;
      end
    end else begin
      ex   = raw[62:52];
      s    = raw[63];
      frac = {12'd0, raw[51:0]};
      if (ex == 2047) begin
        inf = frac == 0;
        nan = !inf;
        m = 0;
        e = 0;
      end else if (ex == 0) begin
        m = frac;
        e = -1074;
      end else begin
        m = frac | (64'd1 << 52);
        e = ex - 1075;
      end
    end
    if (dt >= TYPE_F32) begin
      if (dt == TYPE_F64) begin
        if (inf) r.bits = {s, 11'h7FF, 52'd0};
        else if (nan) r.bits = {s, 11'h7FF, 1'b1, 51'd0} | (frac << 29);
        else r.bits = round_pack(s, m, e, 53, 1023, 2047, 63);
      end else begin
        if (inf) r.bits = {32'd0, s, 31'h7F800000};
        else if (nan) r.bits = {32'd0, s, 31'h7FC00000} | (frac >> 29);
        else r.bits = round_pack(s, m, e, 24, 127, 255, 31);
      end
      return r;
    end
    umax = width_mask(dt);
    smax = umax >> 1;
    mag  = 0;
    huge = 0;
    if (nan) begin
      r.clipped = 1'b1;
      return r;
    end
    if (inf) huge = 1;
    else if (m != 0) begin
      if (e >= 0) begin
        if (msb_index(m) + e >= 64) huge = 1;
        else mag = m << e;
      end else if (e > -64) mag = m >> (-e);
    end
    if (dt < TYPE_I8) begin
      if (s) r.clipped = huge || mag != 0;
      else if (huge || mag > umax) begin
        r.bits = umax;
        r.clipped = 1;
      end else r.bits = mag;
    end else if (!s) begin
      if (huge || mag > smax) begin
        r.bits = smax;
        r.clipped = 1;
      end else r.bits = mag;
    end else begin
      if (huge || mag > smax + 1) begin
        r.bits = (smax + 1) & umax;
        r.clipped = 1;
      end else r.bits = (-mag) & umax;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (!rst) begin
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(convert(in_mon.raw_value, in_mon.source_type,
                                          in_mon.target_type));
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_mon.converted_bits, 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_mon.converted_bits !== want.bits)
            report_mismatch("converted_bits", out_mon.converted_bits, want.bits);
          if (out_mon.range_clipped !== want.clipped)
            report_mismatch("range_clipped", 64'(out_mon.range_clipped), 64'(want.clipped));
          if (out_mon.type_error !== want.bad_type)
            report_mismatch("type_error", 64'(out_mon.type_error), 64'(want.bad_type));
        end
      end
    end
    pending_count = pending_results.size();
  end

endmodule

// ----- tb/sv/tb_numeric_type_converter_unit.sv -----
// Testbench top: drives conversion transactions, throttles both channels, gives the verdict.
`timescale 1ns / 1ps

module tb_numeric_type_converter_unit;
  import ntc_pkg::*;

  localparam int RandomItems  = 1100;
  localparam int WatchdogMax  = 5000;
  localparam int LongHoldOff  = 60;

  // Unsupported type codes used by the directed transactions.
  localparam logic [3:0] BadCodeLow  = 4'd10;
  localparam logic [3:0] BadCodeMid  = 4'd12;
  localparam logic [3:0] BadCodeHigh = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ntc_in_if  in_ch ();
  ntc_out_if out_ch ();

  int fail_count;
  int pending_count;
  int idle_phase = 0;      // 0: sender sparse gaps, 1: receiver sparse, 2: no gaps
  bit hold_receiver = 1'b0;
  bit stimulus_done = 1'b0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  numeric_type_converter_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ntc_checker result_checker (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.raw_value   = '0;
    in_ch.source_type = TYPE_U8;
    in_ch.target_type = TYPE_U8;
    out_ch.ready      = 1'b0;
  end

  // Receiver: random stalls per phase, plus a long hold-off on each request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_receiver) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (idle_phase)
        0: begin
          out_ch.ready <= ($urandom_range(99) >= 75);
        end
        1: begin
          out_ch.ready <= ($urandom_range(99) >= 13);
        end
        default: begin
          out_ch.ready <= 1'b1;
        end
      endcase
    end
  end

  // Hold off the receiver for a counted stretch while the sender keeps offering.
  task automatic hold_off_receiver();
    hold_receiver = 1'b1;
    repeat (LongHoldOff) @(posedge clk);
    hold_receiver = 1'b0;
  endtask

  // Random raw word biased toward interesting float and integer patterns.
  function automatic logic [63:0] pick_raw();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'h000;
      2: v[62:52] = 11'h3FF + 11'($urandom_range(70)) - 11'd5;
      3: v[30:23] = 8'hFF;
      4: v[30:23] = 8'h00;
      5: v[30:23] = 8'd127 + 8'($urandom_range(70)) - 8'd5;
      6: v[62:52] = 11'h380 + 11'($urandom_range(255));
      7: v = 64'($urandom_range(255)) - 64'd128;
      default: ;
    endcase
    return v;
  endfunction

  // Offer one transaction and hold it until accepted; valid stays high
  // afterwards unless the next call idles or the sender is stopped.
  task automatic send_item(input logic [63:0] raw, input logic [3:0] st,
                           input logic [3:0] dt);
    int gap_pct;
    gap_pct = (idle_phase == 0) ? 13 : (idle_phase == 1) ? 75 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.raw_value   <= raw;
    in_ch.source_type <= st;
    in_ch.target_type <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (!stimulus_done || pending_count != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogMax) begin
        $display("numeric_type_converter_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] st, dt;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: integer extremes, float specials, rounding edges, bad codes.
    send_item(64'hFFFF_FFFF_FFFF_FFFF, TYPE_U64, TYPE_F32);
    send_item(64'h8000_0000_0000_0000, TYPE_I64, TYPE_F64);
    send_item(64'h0000_0000_0000_0080, TYPE_I8, TYPE_I64);
    send_item(64'hFFFF_FFFF_FFFF_FF7F, TYPE_I8, TYPE_U16);
    send_item(64'h0000_0000_0100_0001, TYPE_U64, TYPE_F32);
    send_item(64'h0020_0000_0000_0001, TYPE_U64, TYPE_F64);
    send_item(64'd0, TYPE_I32, TYPE_F32);
    send_item(64'h0000_0000_7FC0_1234, TYPE_F32, TYPE_I32);
    send_item(64'hFFF0_0000_0000_0000, TYPE_F64, TYPE_I64);
    send_item(64'h7FF0_0000_0000_0000, TYPE_F64, TYPE_U8);
    send_item(64'hBFE0_0000_0000_0000, TYPE_F64, TYPE_U32);
    send_item(64'hC3E0_0000_0000_0000, TYPE_F64, TYPE_I64);
    send_item(64'h43F0_0000_0000_0000, TYPE_F64, TYPE_U64);
    send_item(64'h0000_0000_7F80_0000, TYPE_F32, TYPE_F64);
    send_item(64'h7FF0_0000_2000_0001, TYPE_F64, TYPE_F32);
    send_item(64'hFFF8_1234_5678_9ABC, TYPE_F64, TYPE_F32);
    send_item(64'h47F0_0000_0000_0000, TYPE_F64, TYPE_F32);
    send_item(64'h3690_0000_0000_0000, TYPE_F64, TYPE_F32);
    send_item(64'h0000_0000_0000_0001, TYPE_F64, TYPE_F32);
    send_item(64'h0000_0000_0000_0001, TYPE_F32, TYPE_F64);
    send_item(64'hDEAD_BEEF_CAFE_F00D, TYPE_U8, TYPE_U8);
    send_item(64'h1234, BadCodeLow, BadCodeLow);
    send_item(64'h1234, TYPE_U8, BadCodeHigh);
    send_item(64'h1234, BadCodeMid, TYPE_F64);
    send_item(64'hC1E0_0000_0020_0000, TYPE_F64, TYPE_I32);

    // Random: mostly valid codes, a few unsupported ones.
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) idle_phase = 1;
      if (i == 2 * RandomItems / 3) idle_phase = 2;
      if (i == RandomItems / 2) begin
        // Pause the sender until every result is in.
        wait_drain();
      end
      if (i == RandomItems / 4 || i == 5 * RandomItems / 6) begin
        fork
          hold_off_receiver();
        join_none
      end
      st = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      dt = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      send_item(pick_raw(), st, dt);
    end

    wait_drain();
    stimulus_done = 1'b1;
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("numeric_type_converter_unit regression: pass");
    end else begin
      $display("numeric_type_converter_unit regression: fail");
    end
    $finish;
  end

endmodule
